FILE: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication, checked in reset as well.
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/mrfe_pkg.sv
`default_nettype none

package mrfe_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAG_W       = SAMPLE_BITS - 1;
    localparam int COEF_W      = 16;
    localparam int TAP_IDX_W   = 5;
    localparam int FRAC_BITS   = 14;
    localparam int ENV_W       = 8;
    localparam int VLEN_W      = 13;
    localparam int VCNT_W      = 11;
    localparam int POS_W       = 12;
    localparam int VIDX_W      = 10;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;

    localparam logic [VLEN_W-1:0] MAX_LEN     = 13'd4096;
    localparam logic [VCNT_W-1:0] MAX_VECTORS = 11'd1024;
    localparam logic [VLEN_W-1:0] VLEN_RESET  = 13'd1024;
    localparam logic [VCNT_W-1:0] VCNT_RESET  = 11'd128;

    localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VECTOR_COUNT  = 2'd1;

    localparam logic KIND_TAP    = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic                        shift;
        logic                        clear;
        logic                        tap_load;
        logic [TAP_IDX_W-1:0]        tap_index;
        logic signed [COEF_W-1:0]    tap_value;
    } t_cell_ctrl;

    function automatic logic [MAG_W-1:0] rectify(input logic signed [SAMPLE_BITS-1:0] s);
        logic [SAMPLE_BITS-1:0] neg;
        logic [MAG_W-1:0]       mag;
        neg = -s;
        if (s == {1'b1, {MAG_W{1'b0}}}) begin
            mag = {MAG_W{1'b1}};
        end else if (s[SAMPLE_BITS-1]) begin
            mag = neg[MAG_W-1:0];
        end else begin
            mag = s[MAG_W-1:0];
        end
        return mag;
    endfunction

endpackage

`default_nettype wire

FILE: design/mrfe_cell.sv
`default_nettype none

module mrfe_cell #(
    parameter int IDX   = 0,
    parameter int SUM_W = 37
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire  mrfe_pkg::t_cell_ctrl           i_ctrl,
    input  wire  [mrfe_pkg::MAG_W-1:0]           i_mag,
    output logic [mrfe_pkg::MAG_W-1:0]           o_mag,
    input  wire  signed [SUM_W-1:0]              i_sum,
    output logic signed [SUM_W-1:0]              o_sum
);
    import mrfe_pkg::*;

    localparam int PROD_W = MAG_W + 1 + COEF_W;

    logic [MAG_W-1:0]          r_mag;
    logic signed [COEF_W-1:0]  r_tap;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [SUM_W-1:0]   r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag <= '0;
        end else if (i_ctrl.clear) begin
            r_mag <= '0;
        end else if (i_ctrl.shift) begin
            r_mag <= i_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.tap_load && (32'(i_ctrl.tap_index) == IDX)) begin
            r_tap <= i_ctrl.tap_value;
        end
        r_prod <= $signed({1'b0, r_mag}) * r_tap;
        r_sum  <= i_sum + {{(SUM_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
    end

    assign o_mag = r_mag;
    assign o_sum = r_sum;

endmodule

`default_nettype wire

FILE: design/masked_rectified_fir_envelope.sv
// Tap load: no result.
// Sample without a filtered result: its results, if any, go out in turn as the output slot frees.
// Sample with a filtered result: the sum passes the product stage and the TAPS-deep accumulation
// chain of the cells before it is registered, then its results go out in turn as the output slot frees.
// Reset (synchronous, active low): clears window, keep line, counters, registers; taps keep.
`default_nettype none

module masked_rectified_fir_envelope #(
    parameter int TAPS = 23
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire                                     i_in_valid,
    output logic                                    o_in_ready,
    input  wire                                     i_kind,
    input  wire  [mrfe_pkg::TAP_IDX_W-1:0]          i_tap_index,
    input  wire  signed [mrfe_pkg::COEF_W-1:0]      i_tap_value,
    input  wire  signed [mrfe_pkg::SAMPLE_BITS-1:0] i_sample,
    input  wire                                     i_keep_bit,
    output logic                                    o_out_valid,
    input  wire                                     i_out_ready,
    output logic [mrfe_pkg::ENV_W-1:0]              o_envelope,
    output logic                                    o_vector_end,
    output logic                                    o_frame_end,
    input  wire                                     i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire  [mrfe_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  wire  [mrfe_pkg::CFG_DATA_W-1:0]         i_cfg_data
);
    import mrfe_pkg::*;

    localparam int HALF        = TAPS / 2;
    localparam int LAG         = TAPS - 1 - HALF;
    localparam int KEEP_DEPTH  = LAG + 1;
    localparam int MID_END_OFF = 1 + HALF - LAG;
    localparam int SUM_W       = 2 * SAMPLE_BITS + $clog2(TAPS);
    localparam int CNT_W       = $clog2(TAPS + 2);
    localparam int TRAIL_W     = $clog2(HALF + 1);
    localparam logic [VLEN_W-1:0] MIN_LEN = VLEN_W'(TAPS + 1);

    t_state                    r_state, n_state;
    logic [VLEN_W-1:0]         r_vlen;
    logic [VCNT_W-1:0]         r_vcnt;
    logic [POS_W-1:0]          r_pos;
    logic [VIDX_W-1:0]         r_vidx;
    logic [KEEP_DEPTH-1:0]     r_keep;
    logic                      r_first_pend;
    logic [ENV_W-1:0]          r_first_env;
    logic [TRAIL_W-1:0]        r_trail;
    logic                      r_last_vec;
    logic [CNT_W-1:0]          r_wait;
    logic                      r_out_valid;
    logic [ENV_W-1:0]          r_out_env;
    logic                      r_out_vend;
    logic                      r_out_fend;

    logic                      smp_acc;
    logic                      tap_acc;
    logic                      cfg_len;
    logic                      cfg_cnt;
    logic [VLEN_W-1:0]         pos_ext;
    logic                      is_lead;
    logic                      is_mid;
    logic                      is_trail;
    logic                      keep_next;
    logic                      last_vec;
    logic                      slot_free;
    logic                      load_out;
    logic                      take_first;
    logic                      calc_done;
    logic [ENV_W-1:0]          env_calc;
    logic [VCNT_W-1:0]         cnt_data;
    t_cell_ctrl                cell_ctrl;
    logic [MAG_W-1:0]          mag_link [TAPS+1];
    logic signed [SUM_W-1:0]   sum_link [TAPS];
    logic signed [SUM_W-1:0]   sum_final;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign smp_acc     = i_in_valid && o_in_ready && (i_kind == KIND_SAMPLE);
    assign tap_acc     = i_in_valid && o_in_ready && (i_kind == KIND_TAP);
    assign cfg_len     = i_cfg_valid && (i_cfg_index == REG_VECTOR_LENGTH);
    assign cfg_cnt     = i_cfg_valid && (i_cfg_index == REG_VECTOR_COUNT);
    assign cnt_data    = i_cfg_data[VCNT_W-1:0];

    assign pos_ext   = {1'b0, r_pos};
    assign is_lead   = pos_ext < VLEN_W'(HALF);
    assign is_mid    = (pos_ext >= VLEN_W'(LAG + HALF))
                    && (pos_ext <= r_vlen - VLEN_W'(MID_END_OFF));
    assign is_trail  = pos_ext >= r_vlen - VLEN_W'(1);
    assign keep_next = r_keep[LAG-1];
    assign last_vec  = {1'b0, r_vidx} >= r_vcnt - VCNT_W'(1);
    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        cell_ctrl.shift     = smp_acc;
        cell_ctrl.clear     = cfg_len || cfg_cnt;
        cell_ctrl.tap_load  = tap_acc;
        cell_ctrl.tap_index = i_tap_index;
        cell_ctrl.tap_value = i_tap_value;
    end

    assign mag_link[TAPS] = rectify(i_sample);

    for (genvar t = 0; t < TAPS; t++) begin : g_cell
        if (t == 0) begin : g_head
            mrfe_cell #(
                .IDX   (t),
                .SUM_W (SUM_W)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (cell_ctrl),
                .i_mag   (mag_link[t+1]),
                .o_mag   (mag_link[t]),
                .i_sum   ('0),
                .o_sum   (sum_link[t])
            );
        end else begin : g_body
            mrfe_cell #(
                .IDX   (t),
                .SUM_W (SUM_W)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (cell_ctrl),
                .i_mag   (mag_link[t+1]),
                .o_mag   (mag_link[t]),
                .i_sum   (sum_link[t-1]),
                .o_sum   (sum_link[t])
            );
        end
    end

    assign sum_final = sum_link[TAPS-1];

    always_comb begin
        if (sum_final[SUM_W-1]) begin
            env_calc = '0;
        end else if (|sum_final[SUM_W-2:FRAC_BITS+ENV_W]) begin
            env_calc = '1;
        end else begin
            env_calc = sum_final[FRAC_BITS+ENV_W-1:FRAC_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        load_out   = 1'b0;
        take_first = 1'b0;
        calc_done  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (smp_acc) begin
                    if (is_mid && keep_next) begin
                        n_state = S_CALC;
                    end else if (is_lead || is_mid || is_trail) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_CALC: begin
                if (r_wait == '0) begin
                    calc_done = 1'b1;
                    n_state   = S_EMIT;
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    load_out   = 1'b1;
                    take_first = r_first_pend;
                    if (r_first_pend ? (r_trail == '0) : (r_trail == TRAIL_W'(1))) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vlen <= VLEN_RESET;
            r_vcnt <= VCNT_RESET;
            r_pos  <= '0;
            r_vidx <= '0;
            r_keep <= '0;
        end else if (cfg_len || cfg_cnt) begin
            if (cfg_len) begin
                if (i_cfg_data < MIN_LEN) begin
                    r_vlen <= MIN_LEN;
                end else if (i_cfg_data > MAX_LEN) begin
                    r_vlen <= MAX_LEN;
                end else begin
                    r_vlen <= i_cfg_data;
                end
            end
            if (cfg_cnt) begin
                if (cnt_data == '0) begin
                    r_vcnt <= VCNT_W'(1);
                end else if (cnt_data > MAX_VECTORS) begin
                    r_vcnt <= MAX_VECTORS;
                end else begin
                    r_vcnt <= cnt_data;
                end
            end
            r_pos  <= '0;
            r_vidx <= '0;
            r_keep <= '0;
        end else if (smp_acc) begin
            r_keep <= {r_keep[KEEP_DEPTH-2:0], i_keep_bit};
            if (is_trail) begin
                r_pos  <= '0;
                r_vidx <= last_vec ? '0 : r_vidx + VIDX_W'(1);
            end else begin
                r_pos <= r_pos + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_pend <= 1'b0;
            r_trail      <= '0;
            r_last_vec   <= 1'b0;
        end else if (smp_acc) begin
            r_first_pend <= is_lead || is_mid;
            r_trail      <= is_trail ? TRAIL_W'(HALF) : '0;
            r_last_vec   <= last_vec;
        end else if (load_out) begin
            if (take_first) begin
                r_first_pend <= 1'b0;
            end else begin
                r_trail <= r_trail - TRAIL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (smp_acc) begin
            r_wait      <= CNT_W'(TAPS + 1);
            r_first_env <= '0;
        end else begin
            if (r_state == S_CALC) begin
                r_wait <= r_wait - CNT_W'(1);
            end
            if (calc_done) begin
                r_first_env <= env_calc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_env  <= take_first ? r_first_env : '0;
            r_out_vend <= !take_first && (r_trail == TRAIL_W'(1));
            r_out_fend <= !take_first && (r_trail == TRAIL_W'(1)) && r_last_vec;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_envelope   = r_out_env;
    assign o_vector_end = r_out_vend;
    assign o_frame_end  = r_out_fend;

endmodule

`default_nettype wire

FILE: design/mrfe_checker.sv
`default_nettype none

`include "assert_macros.svh"

module mrfe_checker (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    input  wire                              i_in_ready,
    input  wire                              i_kind,
    input  wire                              i_out_valid,
    input  wire                              i_out_ready,
    input  wire  [mrfe_pkg::ENV_W-1:0]       i_envelope,
    input  wire                              i_vector_end,
    input  wire                              i_frame_end
);
    import mrfe_pkg::*;

    `ASSERT_IMP(a_frame_end_on_vector_end, i_clk, i_rst_n, i_out_valid && i_frame_end, i_vector_end, "frame end without vector end")
    `ASSERT_IMP(a_vector_end_is_edge, i_clk, i_rst_n, i_out_valid && i_vector_end, i_envelope == '0, "vector end word not zero")
    `ASSERT_NEXT(a_tap_load_no_stall, i_clk, i_rst_n, i_in_valid && i_in_ready && (i_kind == KIND_TAP), i_in_ready, "tap load stalled input")
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_envelope), "output word dropped")
    `ASSERT_NEXT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n, !i_out_valid, "output valid after reset")

endmodule

bind masked_rectified_fir_envelope mrfe_checker u_mrfe_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .i_in_ready   (o_in_ready),
    .i_kind       (i_kind),
    .i_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .i_envelope   (o_envelope),
    .i_vector_end (o_vector_end),
    .i_frame_end  (o_frame_end)
);

`default_nettype wire

FILE: sim/tb_masked_rectified_fir_envelope.sv
`timescale 1ns / 100ps

module tb_masked_rectified_fir_envelope;
    import mrfe_pkg::*;

    localparam int TAPS           = 23;
    localparam int HALF           = TAPS / 2;
    localparam int LAG            = TAPS - 1 - HALF;
    localparam int KEEP_DEPTH     = LAG + 1;
    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 9;
    localparam int SETTLE_CYCLES  = 40;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_TARGET  = 270;
    localparam int REPORT_CAP     = 60;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_COMB
    } t_rx_mode;

    typedef struct packed {
        logic [ENV_W-1:0] envelope;
        logic             vector_end;
        logic             frame_end;
    } t_envelope_word;

    class envelope_scoreboard;
        logic signed [COEF_W-1:0] coef [TAPS];
        logic [MAG_W-1:0]         mags [TAPS];
        logic                     keeps [KEEP_DEPTH];
        int                       position;
        int                       vector_no;
        logic [VLEN_W-1:0]        length_reg;
        logic [VCNT_W-1:0]        count_reg;
        t_envelope_word           awaited [$];
        int                       mismatches;
        int                       checked;
        int                       vector_ends;
        int                       frame_ends;

        function new();
            foreach (coef[t]) coef[t] = '0;
            length_reg  = VLEN_RESET;
            count_reg   = VCNT_RESET;
            mismatches  = 0;
            checked     = 0;
            vector_ends = 0;
            frame_ends  = 0;
            restart_frame();
        endfunction

        function void restart_frame();
            foreach (mags[t]) mags[t] = '0;
            foreach (keeps[t]) keeps[t] = 1'b0;
            position  = 0;
            vector_no = 0;
        endfunction

        function int active_length();
            int l;
            l = int'(length_reg);
            if (l < TAPS + 1) l = TAPS + 1;
            if (l > MAX_LEN) l = MAX_LEN;
            return l;
        endfunction

        function int active_count();
            int c;
            c = int'(count_reg);
            if (c < 1) c = 1;
            if (c > MAX_VECTORS) c = MAX_VECTORS;
            return c;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_VECTOR_LENGTH) begin
                length_reg = data[VLEN_W-1:0];
                restart_frame();
            end else if (idx == REG_VECTOR_COUNT) begin
                count_reg = data[VCNT_W-1:0];
                restart_frame();
            end
        endfunction

        function logic [ENV_W-1:0] filtered_envelope();
            longint acc;
            acc = 0;
            for (int t = 0; t < TAPS; t++) acc += longint'(mags[t]) * longint'(coef[t]);
            if (acc < 0) return '0;
            acc = acc >>> FRAC_BITS;
            if (acc > 255) return 8'd255;
            return 8'(acc);
        endfunction

        function void await_word(logic [ENV_W-1:0] env, logic vend, logic fend);
            t_envelope_word w;
            w.envelope   = env;
            w.vector_end = vend;
            w.frame_end  = fend;
            awaited.push_back(w);
        endfunction

        function void note_word(logic kind, logic [TAP_IDX_W-1:0] tap_index,
                                logic signed [COEF_W-1:0] tap_value,
                                logic signed [SAMPLE_BITS-1:0] echo, logic keep);
            int len;
            int p;
            int q;
            logic last_vector;
            logic signed [SAMPLE_BITS-1:0] negated;
            logic [MAG_W-1:0] mag;
            if (kind == KIND_TAP) begin
                if (tap_index < TAPS) coef[tap_index] = tap_value;
                return;
            end
            negated = -echo;
            if (echo >= 0) begin
                mag = echo[MAG_W-1:0];
            end else if (negated < 0) begin
                mag = '1;
            end else begin
                mag = negated[MAG_W-1:0];
            end
            len = active_length();
            p   = position;
            for (int t = 0; t < TAPS - 1; t++) mags[t] = mags[t + 1];
            mags[TAPS-1] = mag;
            for (int t = KEEP_DEPTH - 1; t > 0; t--) keeps[t] = keeps[t - 1];
            keeps[0] = keep;
            if (p < HALF) await_word('0, 1'b0, 1'b0);
            if (p >= LAG) begin
                q = p - LAG;
                if (q >= HALF && q <= len - 1 - HALF) begin
                    await_word(keeps[LAG] ? filtered_envelope() : '0, 1'b0, 1'b0);
                end
            end
            if (p >= len - 1) begin
                last_vector = (vector_no >= active_count() - 1);
                for (int i = 0; i < HALF; i++) begin
                    await_word('0, i == HALF - 1, (i == HALF - 1) && last_vector);
                end
                position  = 0;
                vector_no = last_vector ? 0 : vector_no + 1;
            end else begin
                position = p + 1;
            end
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= REPORT_CAP) $display("mismatch at %0t: %s", $time, what);
        endtask

        task check_word(logic [ENV_W-1:0] env, logic vend, logic fend);
            t_envelope_word want;
            if (awaited.size() == 0) begin
                report($sformatf("envelope %0d (vend %b fend %b) with nothing awaited",
                                 env, vend, fend));
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (vend === 1'b1) vector_ends++;
            if (fend === 1'b1) frame_ends++;
            if (env !== want.envelope) begin
                report($sformatf("word %0d envelope %0d, predicted %0d",
                                 checked, env, want.envelope));
            end
            if (vend !== want.vector_end) begin
                report($sformatf("word %0d vector_end %b, predicted %b",
                                 checked, vend, want.vector_end));
            end
            if (fend !== want.frame_end) begin
                report($sformatf("word %0d frame_end %b, predicted %b",
                                 checked, fend, want.frame_end));
            end
        endtask
    endclass

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_in_valid  = 1'b0;
    logic                          o_in_ready;
    logic                          i_kind      = KIND_TAP;
    logic [TAP_IDX_W-1:0]          i_tap_index = '0;
    logic signed [COEF_W-1:0]      i_tap_value = '0;
    logic signed [SAMPLE_BITS-1:0] i_sample    = '0;
    logic                          i_keep_bit  = 1'b0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    logic [ENV_W-1:0]              o_envelope;
    logic                          o_vector_end;
    logic                          o_frame_end;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [CFG_IDX_W-1:0]          i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]         i_cfg_data  = '0;

    envelope_scoreboard ledger;
    bit park_receiver = 1'b0;
    int burst_left    = 0;
    int quiet_cycles  = 0;
    int echo_words    = 0;
    int coef_words    = 0;
    int cfg_writes    = 0;
    int holdoffs      = 0;
    int phases        = 0;
    int random_words  = 0;

    logic signed [SAMPLE_BITS-1:0] opening_echo [24] = '{
        16'sh8000, 16'sh7fff, 16'sh0000, -16'sd1, 16'sd1, 16'sh8001,
        16'sd300, -16'sd300, 16'sd150, 16'sd40, -16'sd90, 16'sd5,
        16'sd17, 16'sd260, -16'sd2000, 16'sd64, 16'sd0, 16'sd511,
        -16'sd512, 16'sd1000, 16'sh7ffe, 16'sh8000, 16'sd12, -16'sd7
    };
    logic [23:0] opening_keep = 24'hFAEF3F;

    masked_rectified_fir_envelope #(
        .TAPS(TAPS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_tap_index  (i_tap_index),
        .i_tap_value  (i_tap_value),
        .i_sample     (i_sample),
        .i_keep_bit   (i_keep_bit),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_envelope   (o_envelope),
        .o_vector_end (o_vector_end),
        .o_frame_end  (o_frame_end),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #(CLK_PERIOD / 2.0) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                ledger.check_word(o_envelope, o_vector_end, o_frame_end);
            end
            if ((o_out_valid && i_out_ready) || (i_in_valid && o_in_ready)
                    || (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("no handshake for %0d cycles, %0d envelope words still awaited",
                         quiet_cycles, ledger.awaited.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin : receiver
        t_rx_mode   rx_mode;
        int         span;
        int         step_no;
        logic [7:0] comb;
        rx_mode = RX_OPEN;
        span    = 0;
        step_no = 0;
        comb    = 8'hFF;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (park_receiver) begin
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                park_receiver = 1'b0;
                holdoffs++;
            end else begin
                if (span == 0) begin
                    span    = $urandom_range(40, 240);
                    rx_mode = t_rx_mode'($urandom_range(0, 2));
                    comb    = 8'($urandom) | 8'h01;
                end
                span--;
                case (rx_mode)
                    RX_OPEN: i_out_ready <= 1'b1;
                    RX_COIN: i_out_ready <= 1'($urandom_range(0, 1));
                    default: i_out_ready <= comb[step_no % 8];
                endcase
                step_no++;
                @(posedge i_clk);
            end
        end
    end

    task automatic offer_word(input logic kind, input logic [TAP_IDX_W-1:0] tap_index,
                              input logic signed [COEF_W-1:0] tap_value,
                              input logic signed [SAMPLE_BITS-1:0] echo, input logic keep);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid  <= 1'b1;
        i_kind      <= kind;
        i_tap_index <= tap_index;
        i_tap_value <= tap_value;
        i_sample    <= echo;
        i_keep_bit  <= keep;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        ledger.note_word(kind, tap_index, tap_value, echo, keep);
        if (kind == KIND_TAP) coef_words++;
        else echo_words++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        ledger.write_register(idx, data);
        cfg_writes++;
    endtask

    task automatic settle_block();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (ledger.awaited.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [COEF_W-1:0] pick_coef();
        case ($urandom_range(0, 7))
            0:       return COEF_W'($urandom);
            1:       return -COEF_W'($urandom_range(0, 1500));
            default: return COEF_W'($urandom_range(0, 900));
        endcase
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] pick_echo();
        case ($urandom_range(0, 9))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return '0;
            3, 4:    return SAMPLE_BITS'($urandom);
            default: return SAMPLE_BITS'(int'($urandom_range(0, 800)) - 400);
        endcase
    endfunction

    initial begin : stimulus
        logic [CFG_DATA_W-1:0] length_val;
        logic [CFG_DATA_W-1:0] count_val;
        logic [TAP_IDX_W-1:0]  idx;
        int len;
        int total;
        int keep_bias;
        ledger = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(REG_VECTOR_LENGTH, CFG_DATA_W'(TAPS + 1));
        write_reg(REG_VECTOR_COUNT, 13'd1);
        i_cfg_valid <= 1'b0;
        for (int t = TAPS - 1; t >= 0; t--) begin
            offer_word(KIND_TAP, TAP_IDX_W'(t),
                       (t == 0) ? 16'sh8000 : (t == TAPS - 1) ? 16'sh7fff : 16'(260 + 35 * t),
                       SAMPLE_BITS'($urandom), 1'($urandom));
        end
        // out-of-range indices must leave the coefficients untouched
        offer_word(KIND_TAP, 5'd31, 16'sh7fff, 16'sh8000, 1'b1);
        offer_word(KIND_TAP, 5'd23, 16'sh8000, 16'sh7fff, 1'b0);
        for (int p = 0; p < 24; p++) begin
            offer_word(KIND_SAMPLE, TAP_IDX_W'($urandom), COEF_W'($urandom),
                       opening_echo[p], opening_keep[p]);
        end

        while (random_words < RANDOM_TARGET || phases < 4) begin
            settle_block();
            case (phases)
                0: begin
                    length_val = '1;
                    count_val  = '0;
                end
                1: begin
                    length_val = 13'd4096;
                    count_val  = 13'd1024;
                end
                2: begin
                    length_val = '0;
                    count_val  = '1;
                end
                default: begin
                    case ($urandom_range(0, 9))
                        0:       length_val = CFG_DATA_W'($urandom_range(0, TAPS));
                        1:       length_val = CFG_DATA_W'($urandom_range(4096, 8191));
                        default: length_val = CFG_DATA_W'($urandom_range(TAPS + 1, 2 * TAPS + 2));
                    endcase
                    case ($urandom_range(0, 7))
                        0:       count_val = CFG_DATA_W'($urandom_range(0, 8191));
                        1:       count_val = 13'd1024;
                        default: count_val = CFG_DATA_W'($urandom_range(1, 3));
                    endcase
                end
            endcase
            if ($urandom_range(0, 4) == 0) begin
                write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                          CFG_DATA_W'($urandom));
            end
            if ($urandom_range(0, 1)) begin
                write_reg(REG_VECTOR_LENGTH, length_val);
                write_reg(REG_VECTOR_COUNT, count_val);
            end else begin
                write_reg(REG_VECTOR_COUNT, count_val);
                write_reg(REG_VECTOR_LENGTH, length_val);
            end
            i_cfg_valid <= 1'b0;

            // hold the output back while the input keeps offering words
            if (phases == 3 || (phases > 3 && $urandom_range(0, 5) == 0)) park_receiver = 1'b1;

            if (phases == 3 || $urandom_range(0, 2) == 0) begin
                for (int t = 0; t < TAPS; t++) begin
                    offer_word(KIND_TAP, TAP_IDX_W'(t), pick_coef(),
                               SAMPLE_BITS'($urandom), 1'($urandom));
                    random_words++;
                end
            end

            len = ledger.active_length();
            if (len > 4 * TAPS) begin
                total = $urandom_range(30, 60);
            end else begin
                total = len * $urandom_range(1, 3);
                if ($urandom_range(0, 2) == 0) total += $urandom_range(1, len - 1);
            end
            if (total > RANDOM_TARGET - random_words) total = RANDOM_TARGET - random_words;
            if (total < TAPS + 1) total = TAPS + 1;
            keep_bias = $urandom_range(0, 3);
            for (int n = 0; n < total; n++) begin
                if ($urandom_range(0, 11) == 0) begin
                    idx = TAP_IDX_W'($urandom_range(0, 31));
                    offer_word(KIND_TAP, idx, pick_coef(), SAMPLE_BITS'($urandom), 1'($urandom));
                    random_words++;
                end
                offer_word(KIND_SAMPLE, TAP_IDX_W'($urandom), COEF_W'($urandom), pick_echo(),
                           (keep_bias == 0) ? 1'b1 : 1'($urandom_range(0, 9) < 7));
                random_words++;
            end
            phases++;
        end

        settle_block();
        $display("run: %0d echo and %0d coefficient words in, %0d register writes, %0d phases",
                 echo_words, coef_words, cfg_writes, phases);
        $display("run: %0d envelopes checked, %0d vector ends, %0d frame ends, %0d hold-offs",
                 ledger.checked, ledger.vector_ends, ledger.frame_ends, holdoffs);
        if (ledger.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
